### src/asod_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asod_pkg: shared types and constants
// Register indexes, status codes, datapath command/status structs.
// ---------------------------------------------------------------------------
package asod_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_THR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_T  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_G    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 3'd6;

    localparam logic [1:0] ST_WAIT    = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    localparam logic [2:0] OR_X_UP   = 3'd0;
    localparam logic [2:0] OR_X_DOWN = 3'd1;
    localparam logic [2:0] OR_Y_UP   = 3'd2;
    localparam logic [2:0] OR_Y_DOWN = 3'd3;
    localparam logic [2:0] OR_Z_UP   = 3'd4;
    localparam logic [2:0] OR_Z_DOWN = 3'd5;

    localparam int unsigned TIME_W  = 40;
    localparam int unsigned DISP_W  = 48;
    localparam int unsigned LATE_W  = 7;

    typedef struct packed {
        logic load;     // latch sample, apply start clear, advance time
        logic axis_go;  // process the selected axis
        logic [1:0] axis;
        logic decide;   // stillness / classify / late update
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] orientation;
        logic       still;
    } t_result;

endpackage

### src/asod_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asod_ctrl: sequencer
// Steps one request through load, three axis passes and the decision.
// ---------------------------------------------------------------------------
module asod_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output asod_pkg::t_dp_cmd o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_AX0  = 6'b000010,
        S_AX1  = 6'b000100,
        S_AX2  = 6'b001000,
        S_DEC  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    // hold off requests while in reset and while a request is in progress
    assign o_stall = !i_rst_n || (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd = '0;
        o_cmd.load = accept;
        case (r_state)
            S_AX0: begin o_cmd.axis_go = 1'b1; o_cmd.axis = 2'd0; end
            S_AX1: begin o_cmd.axis_go = 1'b1; o_cmd.axis = 2'd1; end
            S_AX2: begin o_cmd.axis_go = 1'b1; o_cmd.axis = 2'd2; end
            S_DEC: o_cmd.decide = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_AX0;
            S_AX0:  n_state = S_AX1;
            S_AX1:  n_state = S_AX2;
            S_AX2:  n_state = S_DEC;
            S_DEC:  n_state = S_OUT;
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### src/asod_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asod_dp: detector datapath
// Shared per-axis EMA/dispersion unit, time keeping and classification.
// ---------------------------------------------------------------------------
module asod_dp #(
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  asod_pkg::t_dp_cmd            i_cmd,
    input  logic                         i_start_req,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  logic [19:0]                  i_elapsed_us,
    input  logic [31:0]                  i_thr,
    input  logic [31:0]                  i_still_t,
    input  logic [31:0]                  i_timeout,
    input  logic [6:0]                   i_max_late,
    input  logic [14:0]                  i_one_g,
    input  logic [14:0]                  i_tol,
    input  logic [15:0]                  i_weight,
    output asod_pkg::t_result            o_res
);
    localparam int unsigned AVG_W  = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int unsigned MAG_W  = AVG_W;
    localparam int unsigned TW     = asod_pkg::TIME_W;
    localparam int unsigned DW     = asod_pkg::DISP_W;
    // dispersion never exceeds 8 * threshold, so it fits in 35 bits
    localparam int unsigned MW     = (MAG_W > 35) ? MAG_W : 35;
    localparam logic [TW-1:0] TMAX = '1;

    logic signed [AVG_W-1:0] r_avg [3];
    logic [DW-1:0]  r_disp [3];
    logic [TW-1:0]  r_time, r_since;
    logic [TW:0]    r_deadline;
    logic           r_still;
    logic [6:0]     r_late;
    logic [32:0]    r_w;
    logic signed [SAMPLE_BITS-1:0] r_s [3];
    logic           r_all_low, r_any_high;
    asod_pkg::t_result r_res;

    // start clear is folded in by the load step
    logic [TW:0]  tsum;
    logic [35:0]  wprod;
    always_comb begin
        tsum  = {1'b0, (i_start_req ? '0 : r_time)} + {{(TW-19){1'b0}}, i_elapsed_us};
        wprod = {16'd0, i_elapsed_us} * {20'd0, i_weight};
    end

    // shared axis unit
    logic signed [AVG_W-1:0] s_ext, avg_cur, d, avg_new;
    logic [MAG_W-1:0] mag, step;
    logic [DW-1:0]    disp_cur, dstep, disp_dec, sq, clamp, disp_new;
    logic [MAG_W-1:0] qsh;
    logic [31:0]      q;
    logic [63:0]      qq;
    logic [35:0]      thr8;

    // a full weight passes the value through; otherwise a 32-bit fraction
    function automatic logic [DW-1:0] mulw(input logic [MW-1:0] m, input logic [32:0] w);
        logic [MW+32-1:0] p;
        p = {32'd0, m} * {{MW{1'b0}}, w[31:0]};
        return w[32] ? DW'(m) : DW'(p >> 32);
    endfunction

    always_comb begin
        s_ext    = AVG_W'(r_s[i_cmd.axis]) <<< FRAC_BITS;
        avg_cur  = r_avg[i_cmd.axis];
        d        = s_ext - avg_cur;
        mag      = d[AVG_W-1] ? MAG_W'(-d) : MAG_W'(d);
        step     = MAG_W'(mulw(MW'(mag), r_w));
        avg_new  = d[AVG_W-1] ? avg_cur - $signed(step) : avg_cur + $signed(step);
        qsh      = mag >> (FRAC_BITS - 8);
        q        = (qsh > MAG_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(qsh);
        qq       = {32'd0, q} * {32'd0, q};
        sq       = DW'(qq >> 16);
        thr8     = {1'b0, i_thr, 3'd0};
        clamp    = DW'(thr8);
        if (sq > clamp) sq = clamp;
        disp_cur = r_disp[i_cmd.axis];
        dstep    = mulw(MW'(disp_cur[34:0]), r_w);
        disp_dec = disp_cur - dstep;
        disp_new = (sq > disp_dec) ? sq : disp_dec;
    end

    // decision
    logic [TW:0]  since_lim;
    logic [TW:0]  dl_new;
    logic signed [AVG_W-1:0] g, tolv;
    logic [5:0]   nz, np, nn;
    function automatic logic near(input logic signed [AVG_W-1:0] a,
                                  input logic signed [AVG_W-1:0] t,
                                  input logic signed [AVG_W-1:0] tl);
        logic signed [AVG_W:0] df;
        logic [AVG_W:0] m;
        df = (AVG_W+1)'(a) - (AVG_W+1)'(t);
        m  = df[AVG_W] ? (AVG_W+1)'(-df) : (AVG_W+1)'(df);
        return m < (AVG_W+1)'(tl);
    endfunction

    logic [1:0] st;
    logic [2:0] ori;
    logic       still_n;
    logic [TW-1:0] since_n;
    logic [TW:0]   dead_n;
    logic [6:0]    late_n;
    always_comb begin
        g    = AVG_W'({1'b0, i_one_g}) <<< FRAC_BITS;
        tolv = AVG_W'({1'b0, i_tol}) <<< FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            nz[i] = near(r_avg[i], '0, tolv);
            np[i] = near(r_avg[i], g, tolv);
            nn[i] = near(r_avg[i], -g, tolv);
        end
        nz[5:3] = '0; np[5:3] = '0; nn[5:3] = '0;
        since_lim = {1'b0, r_since} + {9'd0, i_still_t};
        dl_new    = {1'b0, r_time} + {9'd0, i_timeout};
        st = asod_pkg::ST_WAIT; ori = asod_pkg::OR_X_UP;
        still_n = r_still; since_n = r_since; dead_n = r_deadline; late_n = r_late;
        if (r_all_low) begin
            if (!r_still) begin
                still_n = 1'b1; since_n = r_time; dead_n = dl_new;
            end else if ({1'b0, r_time} > since_lim) begin
                st = asod_pkg::ST_NOMATCH;
                if (np[0] && nz[1] && nz[2]) begin
                    st = asod_pkg::ST_FOUND; ori = asod_pkg::OR_X_UP;
                end else if (nn[0] && nz[1] && nz[2]) begin
                    st = asod_pkg::ST_FOUND; ori = asod_pkg::OR_X_DOWN;
                end else if (nz[0] && np[1] && nz[2]) begin
                    st = asod_pkg::ST_FOUND; ori = asod_pkg::OR_Y_UP;
                end else if (nz[0] && nn[1] && nz[2]) begin
                    st = asod_pkg::ST_FOUND; ori = asod_pkg::OR_Y_DOWN;
                end else if (nz[0] && nz[1] && np[2]) begin
                    st = asod_pkg::ST_FOUND; ori = asod_pkg::OR_Z_UP;
                end else if (nz[0] && nz[1] && nn[2]) begin
                    st = asod_pkg::ST_FOUND; ori = asod_pkg::OR_Z_DOWN;
                end
            end
        end else if (r_any_high) begin
            still_n = 1'b0;
        end
        if (st == asod_pkg::ST_WAIT) begin
            if (({1'b0, r_time} > dead_n) && (late_n != 7'h7F)) late_n = late_n + 7'd1;
            if (late_n > i_max_late) st = asod_pkg::ST_TIMEOUT;
        end
    end

    logic [33:0] thr4;
    assign thr4 = {i_thr, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_avg[i]  <= '0;
                r_disp[i] <= '0;
            end
            r_time     <= '0;
            r_since    <= '0;
            r_still    <= 1'b0;
            r_deadline <= {9'd0, 32'd30000000};
            r_late     <= '0;
            r_res      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_w  <= (wprod > 36'h1_0000_0000) ? 33'h1_0000_0000 : 33'(wprod);
                r_s[0] <= i_accel_x;
                r_s[1] <= i_accel_y;
                r_s[2] <= i_accel_z;
                r_time <= tsum[TW] ? TMAX : tsum[TW-1:0];
                r_all_low  <= 1'b1;
                r_any_high <= 1'b0;
                if (i_start_req) begin
                    for (int i = 0; i < 3; i++) begin
                        r_avg[i]  <= '0;
                        r_disp[i] <= '0;
                    end
                    r_since    <= '0;
                    r_still    <= 1'b0;
                    r_deadline <= {9'd0, i_timeout};
                    r_late     <= '0;
                end
            end
            if (i_cmd.axis_go) begin
                r_avg[i_cmd.axis]  <= avg_new;
                r_disp[i_cmd.axis] <= disp_new;
                if (!(disp_new < DW'(i_thr))) r_all_low <= 1'b0;
                if (disp_new > DW'(thr4))    r_any_high <= 1'b1;
            end
            if (i_cmd.decide) begin
                r_still    <= still_n;
                r_since    <= since_n;
                r_deadline <= dead_n;
                r_late     <= late_n;
                r_res.status      <= st;
                r_res.orientation <= ori;
                r_res.still       <= still_n;
            end
        end
    end

    assign o_res = r_res;
endmodule

### src/accel_stillness_orientation_detect_top.sv
`timescale 1ns / 1ps
// Sequence: after the accepting edge the request makes three axis passes
// through one shared EMA/dispersion unit, then the decision, then result valid.
// Throughput: a new request is taken only in the idle state, after the result
// has been handed off; an output stall holds the result and the next request.
// Reset: synchronous active-low; registers return to their documented
// defaults, detection state clears and requests are stalled.
// ---------------------------------------------------------------------------
// accel_stillness_orientation_detect_top: stillness and orientation detector
// Config registers, sequencer and datapath.
// ---------------------------------------------------------------------------
module accel_stillness_orientation_detect_top #(
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [asod_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [asod_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_start_req,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  logic [19:0]                   i_elapsed_us,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [2:0]                    o_orientation,
    output logic                          o_still
);
    logic [31:0] r_thr, r_still_t, r_timeout;
    logic [6:0]  r_max_late;
    logic [14:0] r_one_g, r_tol;
    logic [15:0] r_weight;
    asod_pkg::t_dp_cmd cmd;
    asod_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= 32'd2725;
            r_still_t  <= 32'd5000000;
            r_timeout  <= 32'd30000000;
            r_max_late <= 7'd50;
            r_one_g    <= 15'd2048;
            r_tol      <= 15'd1044;
            r_weight   <= 16'd8590;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                asod_pkg::REG_THR:      r_thr      <= i_cfg_data;
                asod_pkg::REG_STILL_T:  r_still_t  <= i_cfg_data;
                asod_pkg::REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                asod_pkg::REG_MAX_LATE: r_max_late <= i_cfg_data[6:0];
                asod_pkg::REG_ONE_G:    r_one_g    <= i_cfg_data[14:0];
                asod_pkg::REG_TOL:      r_tol      <= i_cfg_data[14:0];
                asod_pkg::REG_WEIGHT:   r_weight   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    asod_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .o_cmd(cmd)
    );

    asod_dp #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_start_req(i_start_req),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .i_elapsed_us(i_elapsed_us), .i_thr(r_thr), .i_still_t(r_still_t),
        .i_timeout(r_timeout), .i_max_late(r_max_late), .i_one_g(r_one_g),
        .i_tol(r_tol), .i_weight(r_weight), .o_res(res)
    );

    assign o_status      = res.status;
    assign o_orientation = res.orientation;
    assign o_still       = res.still;
endmodule

### src/asod_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asod_checker: port-level checks
// Watches the top-level ports and is bound to the top level.
// ---------------------------------------------------------------------------
module asod_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [2:0] o_orientation
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while result pending");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall && !o_valid)
        else $error("request not held off after accept");
    a_orient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd1 |-> o_orientation == 3'd0)
        else $error("orientation set without a match");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_orientation <= 3'd5)
        else $error("orientation out of range");
endmodule

bind accel_stillness_orientation_detect_top asod_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_orientation(o_orientation)
);
